// ----- hdl/jsd_pkg.sv -----
// Package for the Jensen-Shannon divergence block: widths, formats and the
// item and log request structures. Used by every module under hdl/.
`timescale 1ns / 1ps
package jsd_pkg;
   localparam int SAMPLE_BITS   = 24;
   localparam int FRACTION_BITS = 16;
   localparam int GUARD_BITS    = 8;
   localparam int MANT_Q        = 28;
   localparam int SQR_STEPS     = FRACTION_BITS + GUARD_BITS;
   localparam int MAX_PAIRS     = 4096;
   localparam int COUNT_BITS    = $clog2(MAX_PAIRS + 1);
   localparam int SUM_BITS      = 52;
   localparam int LOG_BITS      = 24;
   localparam int PROD_BITS     = SAMPLE_BITS + 1 + LOG_BITS;
   localparam int TERM_BITS     = PROD_BITS + 1;
   localparam int CONTRIB_BITS  = PROD_BITS;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] p;
      logic [SAMPLE_BITS-1:0] q;
      logic                   last;
      logic                   p_zero;
      logic                   q_zero;
   } item_type;

   typedef struct packed {
      logic                   start;
      logic [SAMPLE_BITS-1:0] x;
      logic [SAMPLE_BITS:0]   s;
   } log_req_type;
endpackage

// ----- hdl/jsd_front.sv -----
// Front end: accepts sample pairs, flags zero samples and queues them.
// Two-entry queue toward the back end; depends on jsd_pkg.
`timescale 1ns / 1ps
module jsd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [jsd_pkg::SAMPLE_BITS-1:0]     req_p_sample,
   input  logic [jsd_pkg::SAMPLE_BITS-1:0]     req_q_sample,
   input  logic                                req_last_pair,
   output logic                                item_valid,
   output jsd_pkg::item_type                   item,
   input  logic                                item_pop
);
   jsd_pkg::item_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push;

   assign req_stall  = (fill_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (fill_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ item_pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff].p      <= req_p_sample;
         slot_ff[wr_ptr_ff].q      <= req_q_sample;
         slot_ff[wr_ptr_ff].last   <= req_last_pair;
         slot_ff[wr_ptr_ff].p_zero <= (req_p_sample == '0);
         slot_ff[wr_ptr_ff].q_zero <= (req_q_sample == '0);
      end
   end
endmodule

// ----- hdl/jsd_log.sv -----
// Iterative fixed-point log2(2x/s): normalize, bit-serial divide, squaring.
// Shared by both samples of a pair; depends on jsd_pkg.
`timescale 1ns / 1ps
module jsd_log (
   input  logic                                clock,
   input  logic                                reset,
   input  jsd_pkg::log_req_type                req,
   output logic                                done,
   output logic signed [jsd_pkg::LOG_BITS-1:0] result
);
   typedef enum logic [2:0] {L_IDLE, L_NORM, L_DIV, L_SQR, L_DONE} state_type;

   localparam int NB = jsd_pkg::SAMPLE_BITS + 3;
   localparam int YB = jsd_pkg::MANT_Q + 1;

   state_type                     state_ff;
   logic [NB-1:0]                 num_ff;
   logic [jsd_pkg::SAMPLE_BITS:0] s_ff;
   logic signed [6:0]             e_ff;
   logic [4:0]                    cnt_ff;
   logic [YB-1:0]                 y_ff;
   logic [jsd_pkg::SQR_STEPS-1:0] v_ff;
   logic signed [jsd_pkg::LOG_BITS-1:0] result_ff;
   logic                          done_ff;

   logic [NB-1:0]     s_ext, s_dbl, r2;
   logic [2*YB-1:0]   prod;
   logic [YB:0]       sq;
   logic [jsd_pkg::SQR_STEPS:0] rnd;

   assign s_ext  = {2'b00, s_ff};
   assign s_dbl  = {1'b0, s_ff, 1'b0};
   assign r2     = {num_ff[NB-2:0], 1'b0};
   assign prod   = y_ff * y_ff;
   assign sq     = prod[2*YB-1:jsd_pkg::MANT_Q];
   assign rnd    = {1'b0, v_ff} + ((jsd_pkg::SQR_STEPS+1)'(1) << (jsd_pkg::GUARD_BITS - 1));
   assign done   = done_ff;
   assign result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == L_DONE);
         case (state_ff)
            L_IDLE: begin
               if (req.start) begin
                  num_ff   <= {2'b00, req.x, 1'b0};
                  s_ff     <= req.s;
                  e_ff     <= '0;
                  state_ff <= L_NORM;
               end
            end
            L_NORM: begin
               // shift until 2x*2^k reaches s, then take the integer part
               if (num_ff < s_ext) begin
                  num_ff <= {num_ff[NB-2:0], 1'b0};
                  e_ff   <= e_ff - 7'sd1;
               end else begin
                  if (num_ff >= s_dbl) begin
                     num_ff <= '0;
                     e_ff   <= e_ff + 7'sd1;
                  end else begin
                     num_ff <= num_ff - s_ext;
                  end
                  y_ff     <= YB'(1);
                  cnt_ff   <= '0;
                  state_ff <= L_DIV;
               end
            end
            L_DIV: begin
               if (r2 >= s_ext) begin
                  num_ff <= r2 - s_ext;
                  y_ff   <= {y_ff[YB-2:0], 1'b1};
               end else begin
                  num_ff <= r2;
                  y_ff   <= {y_ff[YB-2:0], 1'b0};
               end
               if (cnt_ff == 5'(jsd_pkg::MANT_Q - 1)) begin
                  cnt_ff   <= '0;
                  v_ff     <= '0;
                  state_ff <= L_SQR;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            L_SQR: begin
               y_ff   <= sq[YB] ? sq[YB:1] : sq[YB-1:0];
               v_ff   <= {v_ff[jsd_pkg::SQR_STEPS-2:0], sq[YB]};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(jsd_pkg::SQR_STEPS - 1)) begin
                  state_ff <= L_DONE;
               end
            end
            L_DONE: begin
               result_ff <= {e_ff[6], e_ff, {jsd_pkg::FRACTION_BITS{1'b0}}}
                          + jsd_pkg::LOG_BITS'(rnd[jsd_pkg::SQR_STEPS:jsd_pkg::GUARD_BITS]);
               state_ff  <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end
endmodule

// ----- hdl/jsd_back.sv -----
// Back end: sequences the log unit per sample, forms the term, accumulates
// with saturation and holds the result register. Depends on jsd_pkg, jsd_log.
`timescale 1ns / 1ps
module jsd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   input  jsd_pkg::item_type                   item,
   output logic                                item_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [jsd_pkg::SUM_BITS-1:0]        rsp_divergence,
   output logic                                rsp_saturated
);
   typedef enum logic [2:0] {
      S_IDLE, S_START, S_WAIT, S_ADD, S_CLIP, S_ACC
   } state_type;

   state_type                              state_ff;
   jsd_pkg::item_type                      cur_ff;
   logic                                   sel_ff;
   logic signed [jsd_pkg::PROD_BITS-1:0]   prod_ff;
   logic signed [jsd_pkg::TERM_BITS-1:0]   term_ff;
   logic [jsd_pkg::CONTRIB_BITS-1:0]       contrib_ff;
   logic [jsd_pkg::SUM_BITS-1:0]           sum_ff;
   logic [jsd_pkg::COUNT_BITS-1:0]         count_ff;
   logic                                   ovf_ff;
   logic                                   rsp_valid_ff;
   logic [jsd_pkg::SUM_BITS-1:0]           rsp_div_ff;
   logic                                   rsp_sat_ff;

   jsd_pkg::log_req_type                   log_req;
   logic                                   log_done;
   logic signed [jsd_pkg::LOG_BITS-1:0]    log_result;

   logic [jsd_pkg::SAMPLE_BITS-1:0]        x_sel;
   logic [jsd_pkg::TERM_BITS-1:0]          t_inc;
   logic [jsd_pkg::SUM_BITS:0]             total;
   logic [jsd_pkg::SUM_BITS-1:0]           sum_next;
   logic                                   ovf_next;
   logic [jsd_pkg::COUNT_BITS-1:0]         count_next;
   logic                                   out_busy;
   logic                                   rsp_load;

   assign x_sel         = sel_ff ? cur_ff.q : cur_ff.p;
   assign log_req.start = (state_ff == S_START);
   assign log_req.x     = x_sel;
   assign log_req.s     = {1'b0, cur_ff.p} + {1'b0, cur_ff.q};

   jsd_log u_log (
      .clock  (clock),
      .reset  (reset),
      .req    (log_req),
      .done   (log_done),
      .result (log_result)
   );

   assign item_pop       = (state_ff == S_IDLE) && item_valid;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_divergence = rsp_div_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign out_busy       = rsp_valid_ff && rsp_stall;
   assign rsp_load       = (state_ff == S_ACC) && cur_ff.last && !out_busy;
   assign t_inc          = term_ff + jsd_pkg::TERM_BITS'(1);

   always_comb begin
      total      = {1'b0, sum_ff} + (jsd_pkg::SUM_BITS+1)'(contrib_ff);
      sum_next   = total[jsd_pkg::SUM_BITS] ? '1 : total[jsd_pkg::SUM_BITS-1:0];
      ovf_next   = ovf_ff || total[jsd_pkg::SUM_BITS];
      count_next = count_ff;
      if (count_ff >= jsd_pkg::COUNT_BITS'(jsd_pkg::MAX_PAIRS)) begin
         ovf_next = 1'b1;
      end else begin
         count_next = count_ff + jsd_pkg::COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  cur_ff  <= item;
                  term_ff <= '0;
                  sel_ff  <= item.p_zero;
                  if (item.p_zero && item.q_zero) begin
                     state_ff <= S_CLIP;
                  end else begin
                     state_ff <= S_START;
                  end
               end
            end
            S_START: state_ff <= S_WAIT;
            S_WAIT: begin
               if (log_done) begin
                  prod_ff  <= $signed({1'b0, x_sel}) * log_result;
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               term_ff <= term_ff + jsd_pkg::TERM_BITS'(prod_ff);
               if (!sel_ff && !cur_ff.q_zero) begin
                  sel_ff   <= 1'b1;
                  state_ff <= S_START;
               end else begin
                  state_ff <= S_CLIP;
               end
            end
            S_CLIP: begin
               // halve the term, round half up, clamp negatives
               if (term_ff > 0) begin
                  contrib_ff <= t_inc[jsd_pkg::TERM_BITS-1:1];
               end else begin
                  contrib_ff <= '0;
               end
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (!cur_ff.last) begin
                  sum_ff   <= sum_next;
                  ovf_ff   <= ovf_next;
                  count_ff <= count_next;
                  state_ff <= S_IDLE;
               end else if (!out_busy) begin
                  rsp_div_ff   <= sum_next;
                  rsp_sat_ff   <= ovf_next;
                  sum_ff       <= '0;
                  ovf_ff       <= 1'b0;
                  count_ff     <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- hdl/jensen_shannon_divergence.sv -----
// Jensen-Shannon divergence accumulator, top level.
// Depends on jsd_pkg, jsd_front, jsd_log and jsd_back.
//
// Usage: present one sample pair per req beat (req_p_sample, req_q_sample,
// req_last_pair). A beat is taken when req_valid is high and req_stall low.
// Each pair adds its share of the divergence to a running sum; the beat
// with req_last_pair set yields one rsp beat carrying rsp_divergence
// (unsigned, 16 fraction bits, saturating) and rsp_saturated, then the sum,
// pair count and overflow flag clear for the next vector.
// A pair of two zero samples skips the log unit; each nonzero sample runs
// through the one shared log unit (up to 24 normalize, 28 divide and 24
// squaring steps), one sample after the other. The back end starts a new
// pair only once the current one is done. A two-entry queue decouples
// intake from processing, so req beats are taken while the back end
// works. The result sits in an output register; while rsp_stall holds it,
// non-last pairs still proceed and only a further last pair waits. Reset
// is synchronous and clears the queue, the sum, the count and any pending
// result.
`timescale 1ns / 1ps
module jensen_shannon_divergence (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [jsd_pkg::SAMPLE_BITS-1:0]   req_p_sample,
   input  logic [jsd_pkg::SAMPLE_BITS-1:0]   req_q_sample,
   input  logic                              req_last_pair,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [jsd_pkg::SUM_BITS-1:0]      rsp_divergence,
   output logic                              rsp_saturated
);
   logic              item_valid;
   logic              item_pop;
   jsd_pkg::item_type item;

   jsd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_p_sample  (req_p_sample),
      .req_q_sample  (req_q_sample),
      .req_last_pair (req_last_pair),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   jsd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_divergence (rsp_divergence),
      .rsp_saturated  (rsp_saturated)
   );
endmodule

// ----- test/tb_jensen_shannon_divergence.sv -----
// Testbench for jensen_shannon_divergence: random and directed sample pairs,
// a scoreboard class that predicts each vector's divergence, and random stalls.
// Depends on jsd_pkg and the block under hdl/.
`timescale 1ns / 1ps
module tb_jensen_shannon_divergence;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD  = 600;
   localparam int TAIL_WAIT  = 400;

   class jsd_scoreboard;
      bit [jsd_pkg::SUM_BITS-1:0] acc_sum;
      int unsigned                acc_pairs;
      bit                         acc_ovf;
      bit [jsd_pkg::SUM_BITS:0]   pending_div[$];
      int                         errors;

      function longint log2_of_ratio(bit [63:0] x, bit [63:0] s);
         bit [63:0] num;
         bit [63:0] y;
         bit [63:0] v;
         longint    e;
         num = x << 1;
         e = 0;
         v = 0;
         while (num < s) begin
            num = num << 1;
            e = e - 1;
         end
         y = (num << jsd_pkg::MANT_Q) / s;
         if (y >= (64'd2 << jsd_pkg::MANT_Q)) begin
            y = y >> 1;
            e = e + 1;
         end
         for (int i = 0; i < jsd_pkg::SQR_STEPS; i++) begin
            y = (y * y) >> jsd_pkg::MANT_Q;
            if (y >= (64'd2 << jsd_pkg::MANT_Q)) begin
               y = y >> 1;
               v = (v << 1) | 64'd1;
            end else begin
               v = v << 1;
            end
         end
         v = (v + (64'd1 << (jsd_pkg::GUARD_BITS - 1))) >> jsd_pkg::GUARD_BITS;
         return e * (longint'(1) << jsd_pkg::FRACTION_BITS) + longint'(v);
      endfunction

      function void note_pair(bit [jsd_pkg::SAMPLE_BITS-1:0] p,
                              bit [jsd_pkg::SAMPLE_BITS-1:0] q, bit last);
         bit [63:0] s;
         longint    t;
         bit [63:0] c;
         bit [63:0] room;
         s = 64'(p) + 64'(q);
         t = 0;
         if (p != 0) t += longint'(p) * log2_of_ratio(64'(p), s);
         if (q != 0) t += longint'(q) * log2_of_ratio(64'(q), s);
         c = (t > 0) ? ((64'(t) + 64'd1) >> 1) : 64'd0;
         room = {12'd0, {jsd_pkg::SUM_BITS{1'b1}}} - 64'(acc_sum);
         if (c > room) begin
            acc_sum = {jsd_pkg::SUM_BITS{1'b1}};
            acc_ovf = 1;
         end else begin
            acc_sum = acc_sum + c[jsd_pkg::SUM_BITS-1:0];
         end
         if (acc_pairs >= jsd_pkg::MAX_PAIRS) acc_ovf = 1;
         else acc_pairs++;
         if (last) begin
            pending_div.push_back({acc_ovf, acc_sum});
            acc_sum = 0;
            acc_pairs = 0;
            acc_ovf = 0;
         end
      endfunction

      function void check_result(bit [jsd_pkg::SUM_BITS-1:0] d, bit sat);
         bit [jsd_pkg::SUM_BITS:0] want;
         if (pending_div.size() == 0) begin
            $display("%0t: unexpected result divergence=%0d saturated=%0d", $time, d, sat);
            errors++;
            return;
         end
         want = pending_div.pop_front();
         if (want[jsd_pkg::SUM_BITS-1:0] !== d) begin
            $display("%0t: divergence expected %0d actual %0d", $time,
                     want[jsd_pkg::SUM_BITS-1:0], d);
            errors++;
         end
         if (want[jsd_pkg::SUM_BITS] !== sat) begin
            $display("%0t: saturated expected %0d actual %0d", $time,
                     want[jsd_pkg::SUM_BITS], sat);
            errors++;
         end
      endfunction
   endclass

   logic                            clock = 0;
   logic                            reset = 1;
   logic                            req_valid = 0;
   logic                            req_stall;
   logic [jsd_pkg::SAMPLE_BITS-1:0] req_p_sample = 0;
   logic [jsd_pkg::SAMPLE_BITS-1:0] req_q_sample = 0;
   logic                            req_last_pair = 0;
   logic                            rsp_valid;
   logic                            rsp_stall = 0;
   logic [jsd_pkg::SUM_BITS-1:0]    rsp_divergence;
   logic                            rsp_saturated;

   jsd_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  rsp_taken = 0;
   bit  hold_long = 0;
   bit  calm = 0;

   jensen_shannon_divergence i_dut (.*);

   always #5 clock = ~clock;

   // Watch both channels; count cycles without any beat.
   always @(posedge clock) begin
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_pair(req_p_sample, req_q_sample, req_last_pair);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_divergence, rsp_saturated);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_jensen_shannon_divergence: done, errors");
            $finish;
         end
      end
   end

   // Receiver: random hold-off per result, plus one long hold-off on request.
   initial begin
      int wait_left;
      wait_left = 0;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_stall = 1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_long = 0;
            rsp_stall = 0;
         end else if (wait_left > 0) begin
            rsp_stall = 1;
            wait_left--;
         end else begin
            rsp_stall = 0;
            if (rsp_taken) wait_left = calm ? 0 : int'($urandom_range(0, 16));
         end
      end
   end

   task automatic send_pair(bit [jsd_pkg::SAMPLE_BITS-1:0] p,
                            bit [jsd_pkg::SAMPLE_BITS-1:0] q, bit last);
      int gap;
      req_p_sample = p;
      req_q_sample = q;
      req_last_pair = last;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      gap = calm ? 0 : int'($urandom_range(0, 16));
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid = 0;
      while (sb.pending_div.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic bit [jsd_pkg::SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return jsd_pkg::SAMPLE_BITS'($urandom_range(1, 16));
         2: return {jsd_pkg::SAMPLE_BITS{1'b1}}
                   - jsd_pkg::SAMPLE_BITS'($urandom_range(0, 3));
         default: return jsd_pkg::SAMPLE_BITS'($urandom);
      endcase
   endfunction

   initial begin
      int len;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: zero pairs, full-scale extremes, one-sided samples.
      send_pair(24'd0, 24'd0, 1'b1);
      send_pair({jsd_pkg::SAMPLE_BITS{1'b1}}, 24'd0, 1'b1);
      send_pair(24'd0, {jsd_pkg::SAMPLE_BITS{1'b1}}, 1'b1);
      send_pair({jsd_pkg::SAMPLE_BITS{1'b1}}, {jsd_pkg::SAMPLE_BITS{1'b1}}, 1'b1);
      send_pair(24'd1, {jsd_pkg::SAMPLE_BITS{1'b1}}, 1'b1);
      send_pair({jsd_pkg::SAMPLE_BITS{1'b1}}, 24'd1, 1'b1);
      send_pair(24'd1, 24'd1, 1'b1);
      send_pair(24'd1, 24'd2, 1'b0);
      send_pair(24'd3, 24'd0, 1'b0);
      send_pair(24'd0, 24'd0, 1'b0);
      send_pair(24'd7, 24'd5, 1'b1);
      send_pair(24'h555555, 24'haaaaaa, 1'b0);
      send_pair(24'haaaaaa, 24'h555555, 1'b1);
      send_pair(24'd100, 24'd101, 1'b1);
      drain();

      // Random vectors, mostly short, with one long receiver hold-off.
      for (int n = 0; n < 1800; n += len) begin
         len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 40))
                                           : int'($urandom_range(1, 6));
         calm = ($urandom_range(0, 7) == 0);
         if (n >= 600 && n < 600 + len) hold_long = 1;
         for (int k = 0; k < len; k++) send_pair(pick_sample(), pick_sample(), k == len - 1);
         if (n >= 1200 && n < 1200 + len) drain();
      end
      calm = 0;
      drain();

      if (sb.errors == 0 && sb.pending_div.size() == 0)
         $display("tb_jensen_shannon_divergence: done, clean");
      else
         $display("tb_jensen_shannon_divergence: done, errors");
      $finish;
   end
endmodule
